// File: src/ic3_pkg.sv
// Shared types, constants and helpers for the 3x3 image convolution block.
// No dependencies; used by every module in src.
`default_nettype none

package ic3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int PIX_W      = 8;
   localparam int SUM_W      = 20;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int RSP_DATA_W = 48;

   localparam logic [CSR_DATA_W-1:0] COEF_ROW0_RESET = 24'hFFFFFF;
   localparam logic [CSR_DATA_W-1:0] COEF_ROW1_RESET = 24'hFF09FF;
   localparam logic [CSR_DATA_W-1:0] COEF_ROW2_RESET = 24'hFFFFFF;
   localparam logic [WIDTH_W-1:0]    WIDTH_RESET     = 11'd512;
   localparam logic [HEIGHT_W-1:0]   HEIGHT_RESET    = 13'd512;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_COEF_ROW0    = 3'd0,
      REG_COEF_ROW1    = 3'd1,
      REG_COEF_ROW2    = 3'd2,
      REG_IMAGE_WIDTH  = 3'd3,
      REG_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [2:0][CSR_DATA_W-1:0] coef;
      logic [COL_W-1:0]           width_m1;
      logic [ROW_W-1:0]           height_m1;
   } cfg_type;

   // [row][col], row 2 / col 2 newest
   typedef logic [2:0][2:0][PIX_W-1:0] window_type;

   // offsets into the window of the first and last released output
   typedef struct packed {
      logic       ok;
      logic [1:0] lo;
      logic [1:0] hi;
   } span_type;

   function automatic span_type release_span(input logic [ROW_W-1:0] pos,
                                             input logic [ROW_W-1:0] last);
      span_type s;
      s = '0;
      if (pos < last) begin
         s.ok = (pos >= ROW_W'(2));
         s.lo = 2'd0;
         s.hi = 2'd0;
      end else if (pos == last) begin
         s.ok = 1'b1;
         s.hi = 2'd2;
         if (pos >= ROW_W'(2)) begin
            s.lo = 2'd0;
         end else begin
            s.lo = 2'd2 - pos[1:0];
         end
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// File: src/image_convolution_3x3.sv
// Top level of the 3x3 image convolution block.
// Depends on ic3_pkg, ic3_csr, ic3_line_buf, ic3_mac.
//
// Usage:
//   req_* carries one 8-bit grayscale pixel per transaction in raster order.
//   rsp_* carries one convolution result per transaction: signed sum, row and
//   column of the output; rsp_tlast marks the last result caused by a pixel.
//   Outputs (i,j) are anchored at the window's top-left tap and released with
//   the last pixel they need, so interior pixels give one result, pixels of
//   the last column or last row up to three, the frame's final pixel up to nine.
//   csr_* writes coefficient rows and image size; write only while idle.
// Timing:
//   Pipeline: pixel register, window/line-buffer update, result register. The
//   first result of a pixel reaches rsp through these registers in order.
//   One pixel per cycle is accepted while each pixel gives at most one result
//   and rsp_tready stays high; a pixel giving more results holds the window
//   stage while the single MAC unit forms one result per cycle.
// Reset:
//   Synchronous; clears counters, window and valid flags, loads default
//   coefficients (-1,-1,-1 / -1,9,-1 / -1,-1,-1) and a 512x512 image size.
//   Line buffers are not cleared; rows above the frame's top read as zero.
// Backpressure:
//   When rsp_tready is low the result register holds, the window stage stalls
//   and req_tready drops once the pixel register is occupied.
`default_nettype none

module image_convolution_3x3
   import ic3_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // pixel [7:0]
   input  wire logic [PIX_W-1:0]      req_tdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // sum_value [19:0], out_row [31:20], out_col [41:32], zero [47:42]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   ic3_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // raster position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // pixel register
   logic             s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   span_type         s1_rspan_ff, s1_cspan_ff;

   // window stage
   window_type       window_ff, window_in;
   logic             s2_valid_ff, s2_valid_in;
   logic [COL_W-1:0] s2_col_ff;
   logic [ROW_W-1:0] s2_row_ff;
   logic [1:0]       di_ff, di_in, dj_ff, dj_in;
   logic [1:0]       di_hi_ff, dj_lo_ff, dj_hi_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic [ROW_W-1:0]        rsp_row_ff;
   logic [COL_W-1:0]        rsp_col_ff;
   logic                    rsp_last_ff;

   logic                    accept, xfer, out_free, out_load, s2_end, s2_free;
   logic [2*PIX_W-1:0]      lb_rd_data;
   logic [PIX_W-1:0]        up1, up2;
   logic signed [SUM_W-1:0] mac_sum;
   span_type                rspan, cspan;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = s2_valid_ff && out_free;
   assign s2_end     = (di_ff == di_hi_ff) && (dj_ff == dj_hi_ff);
   assign s2_free    = !s2_valid_ff || (out_load && s2_end);
   assign xfer       = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s2_free;
   assign accept     = req_tvalid && req_tready;

   assign rspan = release_span(row_ff, cfg.height_m1);
   assign cspan = release_span(ROW_W'(col_ff), ROW_W'(cfg.width_m1));

   ic3_line_buf u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (xfer),
      .wr_addr (s1_col_ff),
      .wr_data ({lb_rd_data[PIX_W-1:0], s1_pix_ff}),
      .rd_data (lb_rd_data)
   );

   assign up1 = (s1_row_ff >= ROW_W'(1)) ? lb_rd_data[PIX_W-1:0] : '0;
   assign up2 = (s1_row_ff >= ROW_W'(2)) ? lb_rd_data[2*PIX_W-1:PIX_W] : '0;

   ic3_mac u_mac (
      .win  (window_ff),
      .coef (cfg.coef),
      .di   (di_ff),
      .dj   (dj_ff),
      .sum  (mac_sum)
   );

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff >= cfg.width_m1) begin
            col_in = '0;
            row_in = (row_ff >= cfg.height_m1) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (xfer) begin
         s1_valid_in = 1'b0;
      end

      window_in = window_ff;
      if (xfer) begin
         for (int k = 0; k < 3; k++) begin
            window_in[k][0] = window_ff[k][1];
            window_in[k][1] = window_ff[k][2];
         end
         window_in[0][2] = up2;
         window_in[1][2] = up1;
         window_in[2][2] = s1_pix_ff;
      end

      s2_valid_in = s2_valid_ff;
      di_in       = di_ff;
      dj_in       = dj_ff;
      if (xfer) begin
         s2_valid_in = s1_rspan_ff.ok && s1_cspan_ff.ok;
         di_in       = s1_rspan_ff.lo;
         dj_in       = s1_cspan_ff.lo;
      end else if (out_load) begin
         if (s2_end) begin
            s2_valid_in = 1'b0;
         end else if (dj_ff == dj_hi_ff) begin
            dj_in = dj_lo_ff;
            di_in = di_ff + 2'd1;
         end else begin
            dj_in = dj_ff + 2'd1;
         end
      end

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= '0;
         di_ff        <= '0;
         dj_ff        <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         di_ff        <= di_in;
         dj_ff        <= dj_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_tdata;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_rspan_ff <= rspan;
         s1_cspan_ff <= cspan;
      end
      if (xfer) begin
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
         di_hi_ff  <= s1_rspan_ff.hi;
         dj_lo_ff  <= s1_cspan_ff.lo;
         dj_hi_ff  <= s1_cspan_ff.hi;
      end
      if (out_load) begin
         rsp_sum_ff  <= mac_sum;
         rsp_row_ff  <= s2_row_ff + ROW_W'(di_ff) - ROW_W'(2);
         rsp_col_ff  <= s2_col_ff + COL_W'(dj_ff) - COL_W'(2);
         rsp_last_ff <= s2_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SUM_W - ROW_W - COL_W)'(0),
                        rsp_col_ff, rsp_row_ff, rsp_sum_ff};

endmodule

`default_nettype wire

// File: src/ic3_csr.sv
// Configuration registers: coefficient rows and image size, with size clamping.
// Depends on ic3_pkg.
`default_nettype none

module ic3_csr
   import ic3_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   logic [2:0][CSR_DATA_W-1:0] coef_ff;
   logic [WIDTH_W-1:0]         width_ff;
   logic [HEIGHT_W-1:0]        height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= COEF_ROW0_RESET;
         coef_ff[1] <= COEF_ROW1_RESET;
         coef_ff[2] <= COEF_ROW2_RESET;
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            REG_COEF_ROW0:    coef_ff[0] <= csr_wdata;
            REG_COEF_ROW1:    coef_ff[1] <= csr_wdata;
            REG_COEF_ROW2:    coef_ff[2] <= csr_wdata;
            REG_IMAGE_WIDTH:  width_ff   <= csr_wdata[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_ff  <= csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      cfg.coef = coef_ff;
      if (width_ff == '0) begin
         cfg.width_m1 = '0;
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         cfg.width_m1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         cfg.width_m1 = COL_W'(width_ff - WIDTH_W'(1));
      end
      if (height_ff == '0) begin
         cfg.height_m1 = '0;
      end else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         cfg.height_m1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         cfg.height_m1 = ROW_W'(height_ff - HEIGHT_W'(1));
      end
   end

endmodule

`default_nettype wire

// File: src/ic3_line_buf.sv
// Two line buffers packed in one memory ({older row, previous row} per column),
// registered read with bypass of a same-address write. Depends on ic3_pkg.
`default_nettype none

module ic3_line_buf
   import ic3_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [COL_W-1:0]     rd_addr,
   input  wire logic                 wr_en,
   input  wire logic [COL_W-1:0]     wr_addr,
   input  wire logic [2*PIX_W-1:0]   wr_data,
   output logic      [2*PIX_W-1:0]   rd_data
);

   logic [2*PIX_W-1:0] mem_ff [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic               fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;

endmodule

`default_nettype wire

// File: src/ic3_mac.sv
// 3x3 multiply-accumulate over the window for one output position.
// Depends on ic3_pkg.
`default_nettype none

module ic3_mac
   import ic3_pkg::*;
(
   input  wire window_type             win,
   input  wire logic [2:0][CSR_DATA_W-1:0] coef,
   input  wire logic [1:0]             di,
   input  wire logic [1:0]             dj,
   output logic signed [SUM_W-1:0]     sum
);

   logic [2:0]              rsel;
   logic [2:0]              csel;
   logic [PIX_W-1:0]        tap;
   logic signed [PIX_W-1:0] cf;
   logic signed [2*PIX_W:0] prod;

   // taps that fall outside the window are past the bottom or right edge
   always_comb begin
      sum  = '0;
      rsel = '0;
      csel = '0;
      tap  = '0;
      cf   = '0;
      prod = '0;
      for (int k = 0; k < 3; k++) begin
         for (int l = 0; l < 3; l++) begin
            rsel = {1'b0, di} + 3'(k);
            csel = {1'b0, dj} + 3'(l);
            tap  = '0;
            if (rsel <= 3'd2 && csel <= 3'd2) begin
               tap = win[rsel[1:0]][csel[1:0]];
            end
            cf   = coef[k][8*l +: 8];
            prod = cf * $signed({1'b0, tap});
            sum  = sum + SUM_W'(prod);
         end
      end
   end

endmodule

`default_nettype wire
